// File: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define NPPH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define NPPH_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: hw/rtl/npph_pkg.sv
`default_nettype none

package npph_pkg;

  // default sizes
  localparam int MAX_POINTS_D   = 1024;
  localparam int COORD_BITS_D   = 24;
  localparam int CORDIC_STEPS_D = 16;

  // cordic datapath widths
  localparam int XW = 44;
  localparam int ZW = 34;

  localparam logic signed [XW-1:0] INV_GAIN  = XW'(652032874);
  localparam logic signed [XW-1:0] NORM_LIM  = XW'(64'h100_0000_0000);
  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'h8000_0000);

  // input kinds
  localparam logic [1:0] FN_LOAD  = 2'd0;
  localparam logic [1:0] FN_QUERY = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;

  // result status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_FEW   = 2'd2;
  localparam logic [1:0] ST_NOSEG = 2'd3;

  // atan(2^-i) in units of 2pi/2^32
  function automatic logic [31:0] angle_step(input logic [4:0] i);
    logic [31:0] a;
    unique case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/npph_ram.sv
`default_nettype none

module npph_ram #(
  parameter int W = 48,
  parameter int D = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/npph_cordic.sv
`default_nettype none

module npph_cordic #(
  parameter int STEPS = npph_pkg::CORDIC_STEPS_D
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic                            vec,
  input  wire logic signed [npph_pkg::XW-1:0]  x0,
  input  wire logic signed [npph_pkg::XW-1:0]  y0,
  input  wire logic signed [npph_pkg::ZW-1:0]  z0,
  output logic                                 done,
  output logic signed [npph_pkg::XW-1:0]       x,
  output logic signed [npph_pkg::XW-1:0]       y,
  output logic signed [npph_pkg::ZW-1:0]       z
);
  import npph_pkg::*;

  localparam int SW = (STEPS > 1) ? $clog2(STEPS) : 1;

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_NORM = 2'd1;
  localparam logic [1:0] C_ITER = 2'd2;

  logic [1:0]           phase;
  logic                 mode_vec;
  logic [SW-1:0]        sc;
  logic signed [XW-1:0] ay;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [ZW-1:0] ang;
  logic                 sel;
  logic                 norm_stop;

  // one micro-rotation per cycle
  always_comb begin
    ay        = y[XW-1] ? -y : y;
    norm_stop = (x >= NORM_LIM) || (ay >= NORM_LIM) || ((x == '0) && (y == '0));
    xs        = x >>> sc;
    ys        = y >>> sc;
    ang       = ZW'(angle_step(5'(sc)));
    sel       = mode_vec ? ~y[XW-1] : z[ZW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        C_IDLE: begin
          if (start) begin
            mode_vec <= vec;
            sc       <= '0;
            // vectoring folds the left half plane over first
            if (vec && x0[XW-1]) begin
              x <= -x0;
              y <= -y0;
              z <= HALF_TURN;
            end else begin
              x <= x0;
              y <= y0;
              z <= z0;
            end
            phase <= vec ? C_NORM : C_ITER;
          end
        end
        C_NORM: begin
          // double until the larger magnitude reaches 2^40
          if (norm_stop) begin
            phase <= C_ITER;
          end else begin
            x <= x <<< 1;
            y <= y <<< 1;
          end
        end
        C_ITER: begin
          if (sel) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + ang;
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - ang;
          end
          sc <= sc + 1'b1;
          if (sc == SW'(STEPS - 1)) begin
            phase <= C_IDLE;
            done  <= 1'b1;
          end
        end
        default: phase <= C_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/nearest_path_point_heading.sv
// Nearest path point and segment heading.
// Input stream s_*: s_tuser selects the kind (load point, query, clear table),
// s_tdata carries x then y in mm. Output stream m_*: one transaction per input
// transaction, m_tuser is the status, m_tdata the index, heading, half-angle
// sine/cosine and point count. cfg_wen/cfg_wdata write the minimum squared
// segment length. The user must do so only while the block is idle; the block
// itself does not enforce this. A load, clear or rejected item goes straight
// to the output state. A query scans the stored points (one memory read per
// cycle), then walks the segments from the nearest point, forward first and
// backward if no forward segment qualifies or the nearest point is the last;
// it then normalizes the segment vector and runs two CORDIC passes, vectoring
// then rotation, on the shared iterative unit before loading the output
// register.
// One item is in work at a time; the next is accepted as soon as the finished
// result has moved into the output register, which holds it while m_tready is
// low. Reset empties the table and sets the threshold to 1; point memory is
// not cleared since only entries below the point count are ever read.
`default_nettype none

`include "assert_macros.svh"

module nearest_path_point_heading #(
  parameter int MAX_POINTS   = npph_pkg::MAX_POINTS_D,
  parameter int COORD_BITS   = npph_pkg::COORD_BITS_D,
  parameter int CORDIC_STEPS = npph_pkg::CORDIC_STEPS_D
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // x [COORD_BITS-1:0], y [2*COORD_BITS-1:COORD_BITS], zero fill
  input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]      s_tdata,
  // func
  input  wire logic [1:0]                             s_tuser,
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  // nearest_index[9:0], heading_angle[25:10], quat_z[41:26], quat_w[56:42],
  // point_count[67:57], zero fill
  output logic [71:0]                                 m_tdata,
  // status
  output logic [1:0]                                  m_tuser,
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  input  wire logic                                   cfg_wen,
  input  wire logic [19:0]                            cfg_wdata
);
  import npph_pkg::*;

  localparam int AW   = $clog2(MAX_POINTS);
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int DW   = COORD_BITS + 1;
  localparam int SQW  = 2 * DW;
  localparam int SUMW = SQW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_FWD  = 3'd2;
  localparam logic [2:0] S_BWD  = 3'd3;
  localparam logic [2:0] S_VEC  = 3'd4;
  localparam logic [2:0] S_ROT  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  localparam logic signed [XW-1:0] QMAX = XW'(32767);
  localparam logic signed [XW-1:0] QMIN = -XW'(32768);

  logic [2:0]    state;
  logic [CW-1:0] count;
  logic [19:0]   min_seg;

  // query and search state
  logic signed [COORD_BITS-1:0] qx, qy;
  logic [AW-1:0]                best;
  logic [SUMW-1:0]              best_d;
  logic signed [DW-1:0]         seg_dx, seg_dy;
  logic [15:0]                  head;

  // address sequencer
  logic          issue_on, issue_first, issue_down;
  logic [AW-1:0] issue_addr, issue_end;

  // distance pipeline
  logic                         p1_v, p1_last, p1_first;
  logic [AW-1:0]                p1_idx;
  logic signed [COORD_BITS-1:0] prev_x, prev_y;
  logic                         p2_v, p2_last, p2_first;
  logic [AW-1:0]                p2_idx;
  logic signed [DW-1:0]         p2_dx, p2_dy;
  logic                         p3_v, p3_last, p3_first;
  logic [AW-1:0]                p3_idx;
  logic signed [DW-1:0]         p3_dx, p3_dy;
  logic [SQW-1:0]               p3_sqx, p3_sqy;

  // result holding register
  logic [1:0]    res_status;
  logic [AW-1:0] res_near;
  logic [15:0]   res_head, res_qz;
  logic [14:0]   res_qw;

  // memory and cordic hookup
  logic                    ram_we;
  logic [2*COORD_BITS-1:0] rdata;
  logic signed [COORD_BITS-1:0] rx, ry, ax, ay_p, bx, by;
  logic                    cstart, cvec, cdone;
  logic signed [XW-1:0]    cx0, cy0, cx, cy;
  logic signed [ZW-1:0]    cz0, cz;

  logic                  acc, full;
  logic [SUMW-1:0]       sum;
  logic                  scan_take, seg_hit;
  logic [AW-1:0]         bestn, last_idx;
  logic [31:0]           zr;
  logic [15:0]           head_new;
  logic signed [XW-1:0]  rz, rw;
  logic [15:0]           qz_sat;
  logic [14:0]           qw_sat;

  assign s_tready = (state == S_IDLE);
  assign acc      = s_tvalid & s_tready;
  assign full     = (count >= CW'(MAX_POINTS));
  assign ram_we   = acc && (s_tuser == FN_LOAD) && !full;
  assign last_idx = AW'(count - 1'b1);

  npph_ram #(.W(2 * COORD_BITS), .D(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(count)),
    .wdata (s_tdata[2*COORD_BITS-1:0]),
    .raddr (issue_addr),
    .rdata (rdata)
  );

  // cordic operands: segment vector, then half heading
  assign cx0 = cvec ? XW'(seg_dx) : INV_GAIN;
  assign cy0 = cvec ? XW'(seg_dy) : '0;
  assign cz0 = cvec ? '0 : ZW'($signed({head, 15'b0}));

  npph_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cstart),
    .vec   (cvec),
    .x0    (cx0),
    .y0    (cy0),
    .z0    (cz0),
    .done  (cdone),
    .x     (cx),
    .y     (cy),
    .z     (cz)
  );

  // pair selection and compare stage
  always_comb begin
    rx   = rdata[COORD_BITS-1:0];
    ry   = rdata[2*COORD_BITS-1:COORD_BITS];
    ax   = rx;
    ay_p = ry;
    bx   = qx;
    by   = qy;
    if (state == S_FWD) begin
      bx = prev_x;
      by = prev_y;
    end else if (state == S_BWD) begin
      ax   = prev_x;
      ay_p = prev_y;
      bx   = rx;
      by   = ry;
    end
    sum       = {1'b0, p3_sqx} + {1'b0, p3_sqy};
    scan_take = p3_v && (p3_first || (sum < best_d));
    bestn     = scan_take ? p3_idx : best;
    seg_hit   = p3_v && !p3_first && (sum > SUMW'(min_seg));
  end

  // heading rounding and half-angle sine/cosine saturation
  always_comb begin
    zr       = cz[31:0] + 32'h8000;
    head_new = zr[31:16];
    rz       = (cy + XW'(16384)) >>> 15;
    rw       = (cx + XW'(16384)) >>> 15;
    if (rz > QMAX) begin
      qz_sat = 16'h7fff;
    end else if (rz < QMIN) begin
      qz_sat = 16'h8000;
    end else begin
      qz_sat = rz[15:0];
    end
    if (rw > QMAX) begin
      qw_sat = 15'h7fff;
    end else if (rw[XW-1]) begin
      qw_sat = '0;
    end else begin
      qw_sat = rw[14:0];
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    p1_idx <= issue_addr;
    if (p1_v) begin
      prev_x <= rx;
      prev_y <= ry;
    end
    p2_idx   <= p1_idx;
    p2_dx    <= DW'(ax) - DW'(bx);
    p2_dy    <= DW'(ay_p) - DW'(by);
    p3_idx   <= p2_idx;
    p3_dx    <= p2_dx;
    p3_dy    <= p2_dy;
    p3_sqx   <= SQW'(SQW'(p2_dx) * SQW'(p2_dx));
    p3_sqy   <= SQW'(SQW'(p2_dy) * SQW'(p2_dy));
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      min_seg     <= 20'd1;
      issue_on    <= 1'b0;
      issue_first <= 1'b0;
      p1_v        <= 1'b0;
      p2_v        <= 1'b0;
      p3_v        <= 1'b0;
      cstart      <= 1'b0;
      cvec        <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        min_seg <= cfg_wdata;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      cstart <= 1'b0;

      // address sequencer and valid shift
      if (issue_on) begin
        issue_addr <= issue_down ? issue_addr - 1'b1 : issue_addr + 1'b1;
        if (issue_addr == issue_end) begin
          issue_on <= 1'b0;
        end
      end
      issue_first <= 1'b0;
      p1_v     <= issue_on;
      p1_last  <= issue_on && (issue_addr == issue_end);
      p1_first <= issue_first;
      p2_v     <= p1_v;
      p2_last  <= p1_last;
      p2_first <= p1_first;
      p3_v     <= p2_v;
      p3_last  <= p2_last;
      p3_first <= p2_first;

      unique case (state)
        S_IDLE: begin
          if (acc) begin
            res_status <= ST_OK;
            res_near   <= '0;
            res_head   <= '0;
            res_qz     <= '0;
            res_qw     <= '0;
            state      <= S_OUT;
            case (s_tuser)
              FN_LOAD: begin
                if (full) begin
                  res_status <= ST_FULL;
                end else begin
                  count <= count + 1'b1;
                end
              end
              FN_CLEAR: begin
                count <= '0;
              end
              FN_QUERY: begin
                if (count < CW'(2)) begin
                  res_status <= ST_FEW;
                end else begin
                  qx          <= s_tdata[COORD_BITS-1:0];
                  qy          <= s_tdata[2*COORD_BITS-1:COORD_BITS];
                  issue_on    <= 1'b1;
                  issue_first <= 1'b1;
                  issue_down  <= 1'b0;
                  issue_addr  <= '0;
                  issue_end   <= last_idx;
                  state       <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (scan_take) begin
            best   <= p3_idx;
            best_d <= sum;
          end
          if (p3_v && p3_last) begin
            res_near    <= bestn;
            p1_v        <= 1'b0;
            p2_v        <= 1'b0;
            p3_v        <= 1'b0;
            issue_on    <= 1'b1;
            issue_first <= 1'b1;
            issue_addr  <= bestn;
            // no forward segment from the last point
            if (bestn == last_idx) begin
              issue_down <= 1'b1;
              issue_end  <= '0;
              state      <= S_BWD;
            end else begin
              issue_down <= 1'b0;
              issue_end  <= last_idx;
              state      <= S_FWD;
            end
          end
        end
        S_FWD, S_BWD: begin
          if (seg_hit) begin
            seg_dx   <= p3_dx;
            seg_dy   <= p3_dy;
            p1_v     <= 1'b0;
            p2_v     <= 1'b0;
            p3_v     <= 1'b0;
            issue_on <= 1'b0;
            cstart   <= 1'b1;
            cvec     <= 1'b1;
            state    <= S_VEC;
          end else if (p3_v && p3_last) begin
            p1_v     <= 1'b0;
            p2_v     <= 1'b0;
            p3_v     <= 1'b0;
            issue_on <= 1'b0;
            // forward failed: walk back unless already at the first point
            if ((state == S_FWD) && (best != '0)) begin
              issue_on    <= 1'b1;
              issue_first <= 1'b1;
              issue_down  <= 1'b1;
              issue_addr  <= best;
              issue_end   <= '0;
              state       <= S_BWD;
            end else begin
              res_status <= ST_NOSEG;
              state      <= S_OUT;
            end
          end
        end
        S_VEC: begin
          if (cdone) begin
            head   <= head_new;
            cstart <= 1'b1;
            cvec   <= 1'b0;
            state  <= S_ROT;
          end
        end
        S_ROT: begin
          if (cdone) begin
            res_head <= head;
            res_qz   <= qz_sat;
            res_qw   <= qw_sat;
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {4'b0, 11'(count), res_qw, res_qz, res_head, 10'(res_near)};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `NPPH_ASSERT(a_count_max, count <= CW'(MAX_POINTS), "point count above table size")
  `NPPH_ASSERT(a_ram_we_idle, ram_we |-> (state == S_IDLE), "point write outside idle")
  `NPPH_NEVER(a_issue_walk, issue_on && !(state == S_SCAN || state == S_FWD || state == S_BWD), "memory reads outside scan or walk")
  `NPPH_ASSERT(a_cdone_state, cdone |-> (state == S_VEC || state == S_ROT), "cordic finished with no consumer")

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`default_nettype none

module testbench;
  import npph_pkg::*;

  // one result as it leaves the block
  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  nearest;
    logic [15:0] heading;
    logic [15:0] qz;
    logic [14:0] qw;
    logic [10:0] count;
  } path_result_t;

  localparam int TABLE_DEPTH = 1024;
  localparam logic [1:0] FN_UNUSED = 2'd3;
  localparam longint ATAN_TBL [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  logic        clk;
  logic        rst;
  logic [47:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic        cfg_wen;
  logic [19:0] cfg_wdata;

  nearest_path_point_heading dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  // shadow copy of the point table and threshold
  longint       pts_x [TABLE_DEPTH];
  longint       pts_y [TABLE_DEPTH];
  int           pts_count;
  logic [19:0]  min_len_sq;
  path_result_t pending_results [$];
  int           err_count;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           recv_hold_cycles;
  longint       last_x;
  longint       last_y;

  // clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic longint dist_sq(longint dx, longint dy);
    return dx * dx + dy * dy;
  endfunction

  // vectoring cordic: heading of (dx, dy) in 2pi/65536 units
  function automatic logic [15:0] seg_heading(longint dx, longint dy);
    longint x, y, z, ay, m, xs, ys;
    logic [31:0] ang;
    x = dx;
    y = dy;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 64'sd2147483648;
    end
    forever begin
      ay = (y < 0) ? -y : y;
      m = (x > ay) ? x : ay;
      if (m >= 64'sd1099511627776 || m == 0) break;
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_TBL[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_TBL[i];
      end
    end
    ang = z[31:0] + 32'h8000;
    return ang[31:16];
  endfunction

  // rotation cordic: sine and cosine of half the heading
  function automatic void half_angle_sc(logic [15:0] head, output logic [15:0] qz,
                                        output logic [14:0] qw);
    longint x, y, z, xs, ys, s, c;
    z = longint'($signed(head)) * 32768;
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_TBL[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_TBL[i];
      end
    end
    s = (y + 16384) >>> 15;
    c = (x + 16384) >>> 15;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    if (c > 32767) c = 32767;
    if (c < 0) c = 0;
    qz = s[15:0];
    qw = c[14:0];
  endfunction

  // expected result of one accepted transaction, updates the shadow table
  function automatic path_result_t predict_path(logic [1:0] fn, logic [23:0] xr,
                                                logic [23:0] yr);
    path_result_t r;
    longint cx, cy, d, best_d;
    int best, seg;
    bit found;
    r = '0;
    cx = longint'($signed(xr));
    cy = longint'($signed(yr));
    if (fn == FN_LOAD) begin
      if (pts_count >= TABLE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pts_x[pts_count] = cx;
        pts_y[pts_count] = cy;
        pts_count++;
      end
    end else if (fn == FN_CLEAR) begin
      pts_count = 0;
    end else if (fn == FN_QUERY) begin
      if (pts_count < 2) begin
        r.status = ST_FEW;
      end else begin
        best = 0;
        seg = 0;
        found = 0;
        best_d = dist_sq(pts_x[0] - cx, pts_y[0] - cy);
        for (int i = 1; i < pts_count; i++) begin
          d = dist_sq(pts_x[i] - cx, pts_y[i] - cy);
          if (d < best_d) begin
            best_d = d;
            best = i;
          end
        end
        for (int i = best; i + 1 < pts_count && !found; i++)
          if (dist_sq(pts_x[i+1] - pts_x[i], pts_y[i+1] - pts_y[i]) > longint'(min_len_sq)) begin
            found = 1;
            seg = i + 1;
          end
        for (int i = best; i > 0 && !found; i--)
          if (dist_sq(pts_x[i] - pts_x[i-1], pts_y[i] - pts_y[i-1]) > longint'(min_len_sq)) begin
            found = 1;
            seg = i;
          end
        r.nearest = best[9:0];
        if (!found) begin
          r.status = ST_NOSEG;
        end else begin
          r.heading = seg_heading(pts_x[seg] - pts_x[seg-1], pts_y[seg] - pts_y[seg-1]);
          half_angle_sc(r.heading, r.qz, r.qw);
        end
      end
    end
    r.count = pts_count[10:0];
    return r;
  endfunction

  // offer one transaction, wait for acceptance
  task automatic send_item(logic [1:0] fn, logic [23:0] x, logic [23:0] y);
    forever begin
      @(negedge clk);
      if ($urandom_range(99) < send_idle_pct) begin
        s_tvalid <= 1'b0;
      end else begin
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {y, x};
        break;
      end
    end
    do @(posedge clk); while (!s_tready);
    pending_results = {pending_results, predict_path(fn, x, y)};
  endtask

  // sender pause until every result is back
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_threshold(logic [19:0] v);
    wait_drained();
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    min_len_sq = v;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  function automatic logic [23:0] any_coord();
    return 24'($urandom());
  endfunction

  // next point a small random step from the last one
  function automatic logic [23:0] near_coord(longint base, int span);
    longint v;
    v = base + $urandom_range(2 * span) - span;
    return v[23:0];
  endfunction

  // receiver: random stalls plus long hold-offs on request
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (recv_hold_cycles > 0) begin
      m_tready <= 1'b0;
      recv_hold_cycles <= recv_hold_cycles - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result check against oldest expectation
  always @(posedge clk) begin
    path_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction");
        err_count++;
      end else begin
        e = pending_results.pop_front();
        if (m_tuser != e.status) begin
          $error("status exp %0d got %0d", e.status, m_tuser);
          err_count++;
        end
        if (m_tdata[9:0] != e.nearest) begin
          $error("nearest_index exp %0d got %0d", e.nearest, m_tdata[9:0]);
          err_count++;
        end
        if (m_tdata[25:10] != e.heading) begin
          $error("heading_angle exp %0d got %0d", $signed(e.heading),
                 $signed(m_tdata[25:10]));
          err_count++;
        end
        if (m_tdata[41:26] != e.qz) begin
          $error("quat_z exp %0d got %0d", $signed(e.qz), $signed(m_tdata[41:26]));
          err_count++;
        end
        if (m_tdata[56:42] != e.qw) begin
          $error("quat_w exp %0d got %0d", e.qw, m_tdata[56:42]);
          err_count++;
        end
        if (m_tdata[67:57] != e.count) begin
          $error("point_count exp %0d got %0d", e.count, m_tdata[67:57]);
          err_count++;
        end
        if (m_tdata[71:68] != 4'd0) begin
          $error("zero fill exp 0 got %0h", m_tdata[71:68]);
          err_count++;
        end
      end
    end
  end

  // extremes, every kind, short tables, ties, zero-length segments
  task automatic test_directed();
    send_item(FN_QUERY, 24'd0, 24'd0);
    send_item(FN_LOAD, 24'h7FFFFF, 24'h800000);
    send_item(FN_QUERY, 24'd5, 24'd5);
    send_item(FN_LOAD, 24'h800000, 24'h7FFFFF);
    send_item(FN_QUERY, 24'h7FFFFF, 24'h7FFFFF);
    send_item(FN_QUERY, 24'h800000, 24'h800000);
    send_item(FN_QUERY, 24'd0, 24'd0);
    send_item(FN_UNUSED, 24'hFFFFFF, 24'hFFFFFF);
    send_item(FN_CLEAR, 24'hFFFFFF, 24'hFFFFFF);
    send_item(FN_LOAD, 24'd100, 24'd100);
    send_item(FN_LOAD, 24'd100, 24'd100);
    send_item(FN_QUERY, 24'd0, 24'd0);
    send_item(FN_LOAD, 24'd101, 24'd100);
    send_item(FN_QUERY, 24'd100, 24'd100);
    send_item(FN_LOAD, 24'hFFFFF6, 24'd100);
    send_item(FN_QUERY, 24'hFFFFFF, 24'd100);
    send_item(FN_LOAD, 24'hFFFFF6, 24'hFFFFF6);
    send_item(FN_LOAD, 24'd50, 24'hFFFFF6);
    send_item(FN_QUERY, 24'd50, 24'hFFFFF6);
    send_item(FN_QUERY, 24'd20, 24'd0);
    send_item(FN_CLEAR, 24'd0, 24'd0);
  endtask

  // threshold extremes on a fixed path
  task automatic test_threshold_extremes();
    write_threshold(20'd0);
    send_item(FN_LOAD, 24'd0, 24'd0);
    send_item(FN_LOAD, 24'd0, 24'd0);
    send_item(FN_LOAD, 24'd0, 24'd1);
    send_item(FN_LOAD, 24'd1023, 24'd0);
    send_item(FN_QUERY, 24'd0, 24'd0);
    write_threshold(20'hFFFFF);
    send_item(FN_QUERY, 24'd0, 24'd0);
    send_item(FN_LOAD, 24'd0, 24'd0);
    send_item(FN_QUERY, 24'd1023, 24'd0);
    send_item(FN_CLEAR, 24'd0, 24'd0);
    write_threshold(20'd1);
  endtask

  // receiver held off for a long stretch while loads and queries keep coming
  task automatic test_long_stall();
    longint x, y;
    x = 0;
    y = 0;
    wait_drained();
    send_item(FN_CLEAR, 24'd0, 24'd0);
    recv_hold_cycles = 400;
    for (int i = 0; i < 40; i++) begin
      x = x + $urandom_range(40) - 10;
      y = y + $urandom_range(40) - 10;
      send_item(FN_LOAD, x[23:0], y[23:0]);
    end
    send_item(FN_QUERY, x[23:0], y[23:0]);
    send_item(FN_QUERY, 24'd0, 24'd0);
    send_item(FN_QUERY, any_coord(), any_coord());
    send_item(FN_CLEAR, 24'd0, 24'd0);
  endtask

  // random paths with queries, some noise
  task automatic test_random_paths(int n_items);
    int sent, n_pts, span;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_item(2'($urandom_range(3)), any_coord(), any_coord());
        sent++;
        continue;
      end
      send_item(FN_CLEAR, any_coord(), any_coord());
      n_pts = $urandom_range(1, 20);
      span = ($urandom_range(3) == 0) ? 3 : 2000;
      last_x = longint'($signed(any_coord()));
      last_y = longint'($signed(any_coord()));
      for (int i = 0; i < n_pts; i++) begin
        if ($urandom_range(7) == 0) begin
          last_x = longint'($signed(any_coord()));
          last_y = longint'($signed(any_coord()));
        end else begin
          last_x = longint'($signed(near_coord(last_x, span)));
          last_y = longint'($signed(near_coord(last_y, span)));
        end
        send_item(FN_LOAD, last_x[23:0], last_y[23:0]);
      end
      for (int q = $urandom_range(1, 4); q > 0; q--)
        send_item(FN_QUERY, near_coord(last_x, 20000), near_coord(last_y, 20000));
      sent += n_pts + 2;
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    err_count = 0;
    recv_hold_cycles = 0;
    pts_count = 0;
    min_len_sq = 20'd1;
    send_idle_pct = 9;
    recv_idle_pct = 76;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_threshold_extremes();
    test_random_paths(140);
    write_threshold(20'd400);
    send_idle_pct = 76;
    recv_idle_pct = 9;
    test_random_paths(140);
    test_long_stall();
    write_threshold(20'($urandom_range(20'hFFFFF)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_paths(140);
    write_threshold(20'd4000);
    test_random_paths(30);

    wait_drained();
    repeat (50) @(posedge clk);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #60000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire

// File: nearest_path_point_heading.f
+incdir+hw/rtl
hw/rtl/npph_pkg.sv
hw/rtl/npph_ram.sv
hw/rtl/npph_cordic.sv
hw/rtl/nearest_path_point_heading.sv
tb/sv/testbench.sv
